// ===== rtl/core/mtsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsf_pkg
// Shared types and constants of the steering framer: frame request record,
// frame field constants and configuration register indexes.
// ----------------------------------------------------------------------------
package mtsf_pkg;

    localparam int SENSOR_COUNT = 16;
    localparam int SPEED_W      = 10;
    localparam int FRAME_LEN    = 16;
    localparam int BYTE_IDX_W   = $clog2(FRAME_LEN);

    // configuration register indexes
    localparam logic CFG_STATION_ADDR = 1'b0;
    localparam logic CFG_SPEED_BIAS   = 1'b1;

    // fixed frame contents: function code 0x16, start 0x0038, four regs
    localparam logic [7:0] FRAME_FUNC    = 8'h16;
    localparam logic [7:0] FRAME_REG_LO  = 8'h38;
    localparam logic [7:0] FRAME_REG_CNT = 8'h04;

    // frame byte positions with named contents; all other bytes are zero
    localparam logic [BYTE_IDX_W-1:0] BYTE_ADDR   = 4'd0;
    localparam logic [BYTE_IDX_W-1:0] BYTE_FUNC   = 4'd1;
    localparam logic [BYTE_IDX_W-1:0] BYTE_REG_LO = 4'd3;
    localparam logic [BYTE_IDX_W-1:0] BYTE_CNT    = 4'd5;
    localparam logic [BYTE_IDX_W-1:0] BYTE_LH     = 4'd8;
    localparam logic [BYTE_IDX_W-1:0] BYTE_LL     = 4'd9;
    localparam logic [BYTE_IDX_W-1:0] BYTE_RH     = 4'd12;
    localparam logic [BYTE_IDX_W-1:0] BYTE_RL     = 4'd13;
    localparam logic [BYTE_IDX_W-1:0] BYTE_CRC_LO = 4'd14;
    localparam logic [BYTE_IDX_W-1:0] BYTE_CRC_HI = 4'd15;

    typedef logic [SPEED_W-1:0] t_speed;

    typedef struct packed {
        t_speed left;
        t_speed right;
    } t_frame_req;

endpackage

// ===== rtl/core/mtsf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsf_front
// Takes control ticks, keeps steering state and queues frame requests.
// ----------------------------------------------------------------------------
module mtsf_front
    import mtsf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [SENSOR_COUNT-1:0] i_hall_bits,
    input  logic                    i_card_event,
    input  logic [3:0]              i_card_code,
    input  logic                    i_run_enable,
    input  logic [9:0]              i_speed_bias,
    input  logic                    i_q_full,
    output logic                    o_push,
    output t_frame_req              o_push_req
);

    localparam logic [3:0] MAN_NORMAL     = 4'd0;
    localparam logic [3:0] MAN_LAST_TIMED = 4'd7;
    localparam logic [3:0] MAN_STOP       = 4'd8;
    localparam logic [4:0] TICK_MAX       = 5'd31;
    localparam t_speed     SPEED_MAX      = 10'd1023;

    localparam logic [6:0] WEIGHT_TAB [8] = '{7'd65, 7'd40, 7'd30, 7'd25,
                                              7'd25, 7'd25, 7'd25, 7'd20};

    typedef struct packed {
        t_speed     left;
        t_speed     right;
        logic [4:0] limit;
    } t_man_entry;

    function automatic t_man_entry man_entry(input logic [3:0] code);
        t_man_entry e;
        case (code)
            4'd1:    e = '{10'd200, 10'd200, 5'd20};
            4'd2:    e = '{10'd10,  10'd100, 5'd7};
            4'd3:    e = '{10'd10,  10'd100, 5'd7};
            4'd4:    e = '{10'd100, 10'd10,  5'd7};
            4'd5:    e = '{10'd160, 10'd16,  5'd2};
            4'd6:    e = '{10'd0,   10'd0,   5'd20};
            4'd7:    e = '{10'd200, 10'd200, 5'd5};
            default: e = '0;
        endcase
        return e;
    endfunction

    // upper side walks sensors 15 down to 8, lower side 0 up to 7
    function automatic t_speed weighted(input logic [7:0] bits, input logic [9:0] bias);
        logic [10:0] sum;
        sum = {1'b0, bias};
        for (int k = 0; k < 8; k++) begin
            if (bits[k]) begin
                sum = sum + {4'd0, WEIGHT_TAB[k]};
            end
        end
        return (sum > {1'b0, SPEED_MAX}) ? SPEED_MAX : sum[SPEED_W-1:0];
    endfunction

    logic [3:0]  r_man,   n_man;
    logic [4:0]  r_tick,  n_tick;
    t_speed      r_left,  n_left;
    t_speed      r_right, n_right;

    logic        accept;
    logic [3:0]  run_man;
    logic [7:0]  upper_bits;
    t_man_entry  man;
    t_speed      sum_left;
    t_speed      sum_right;
    logic [4:0]  tick_inc;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign run_man = i_card_event ? i_card_code : r_man;
    assign man     = man_entry(run_man);
    assign tick_inc = (r_tick == TICK_MAX) ? r_tick : r_tick + 5'd1;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            upper_bits[k] = i_hall_bits[SENSOR_COUNT-1-k];
        end
    end

    assign sum_right = weighted(upper_bits, i_speed_bias);
    assign sum_left  = weighted(i_hall_bits[7:0], i_speed_bias);

    always_comb begin
        n_man      = r_man;
        n_tick     = r_tick;
        n_left     = r_left;
        n_right    = r_right;
        o_push     = 1'b0;
        o_push_req = '0;
        if (accept) begin
            if (!i_run_enable) begin
                o_push = 1'b1;
            end else begin
                n_man = run_man;
                if (run_man == MAN_NORMAL) begin
                    o_push = 1'b1;
                    if (i_hall_bits == '0) begin
                        // lost track: repeat the last speeds
                        o_push_req = '{r_left, r_right};
                    end else begin
                        n_left     = sum_left;
                        n_right    = sum_right;
                        o_push_req = '{sum_left, sum_right};
                    end
                end else if (run_man <= MAN_LAST_TIMED) begin
                    if (r_tick < man.limit) begin
                        n_left     = man.left;
                        n_right    = man.right;
                        n_tick     = tick_inc;
                        o_push     = 1'b1;
                        o_push_req = '{man.left, man.right};
                    end else begin
                        // manoeuvre done: back to track steering, silent tick
                        n_man  = MAN_NORMAL;
                        n_tick = '0;
                    end
                end else if (run_man == MAN_STOP) begin
                    n_left  = '0;
                    n_right = '0;
                    n_tick  = tick_inc;
                    o_push  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_man   <= MAN_NORMAL;
            r_tick  <= '0;
            r_left  <= '0;
            r_right <= '0;
        end else begin
            r_man   <= n_man;
            r_tick  <= n_tick;
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    a_stop_holds_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_run_enable && run_man == MAN_STOP) |=> (r_left == '0 && r_right == '0))
        else $error("stop did not clear speeds");

endmodule

// ===== rtl/core/mtsf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsf_queue
// Small register FIFO of frame requests between the front and back parts.
// ----------------------------------------------------------------------------
module mtsf_queue
    import mtsf_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_req i_push_req,
    output logic       o_full,
    output logic       o_valid,
    output t_frame_req o_req,
    input  logic       i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_frame_req       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_req   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count past depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

// ===== rtl/core/mtsf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsf_back
// Serializes frame requests into 16 bytes with a running Modbus CRC16.
// ----------------------------------------------------------------------------
module mtsf_back
    import mtsf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_station_address,
    input  logic       i_q_valid,
    input  t_frame_req i_q_req,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_frame_byte,
    output logic       o_frame_last
);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'd0, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    logic                  r_busy;
    logic [BYTE_IDX_W-1:0] r_idx;
    t_frame_req            r_req;
    logic [15:0]           r_crc;
    logic                  r_valid;
    logic [7:0]            r_byte;
    logic                  r_last;

    logic                  advance;
    logic                  at_end;
    logic [7:0]            cur_byte;
    logic [15:0]           crc_base;

    assign advance = r_busy && (!r_valid || !i_stall);
    assign at_end  = (r_idx == BYTE_CRC_HI);
    assign o_pop   = i_q_valid && (!r_busy || (advance && at_end));

    assign o_valid      = r_valid;
    assign o_frame_byte = r_byte;
    assign o_frame_last = r_last;

    assign crc_base = (r_idx == BYTE_ADDR) ? CRC_INIT : r_crc;

    always_comb begin
        case (r_idx)
            BYTE_ADDR:   cur_byte = i_station_address;
            BYTE_FUNC:   cur_byte = FRAME_FUNC;
            BYTE_REG_LO: cur_byte = FRAME_REG_LO;
            BYTE_CNT:    cur_byte = FRAME_REG_CNT;
            BYTE_LH:     cur_byte = {6'd0, r_req.left[SPEED_W-1:8]};
            BYTE_LL:     cur_byte = r_req.left[7:0];
            BYTE_RH:     cur_byte = {6'd0, r_req.right[SPEED_W-1:8]};
            BYTE_RL:     cur_byte = r_req.right[7:0];
            BYTE_CRC_LO: cur_byte = r_crc[7:0];
            BYTE_CRC_HI: cur_byte = r_crc[15:8];
            default:     cur_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_idx < BYTE_CRC_LO) begin
            r_crc <= crc_byte(crc_base, cur_byte);
        end
        if (advance) begin
            r_byte <= cur_byte;
            r_last <= at_end;
        end
        if (o_pop) begin
            r_req <= i_q_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                r_idx   <= r_idx + 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (advance && at_end) begin
                r_busy <= 1'b0;
            end
        end
    end

    a_idle_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_idx == BYTE_ADDR))
        else $error("byte index off frame start while idle");

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && at_end) |=> (o_frame_last && r_idx == BYTE_ADDR))
        else $error("frame end not marked or index not wrapped");

endmodule

// ===== rtl/core/magnetic_track_steering_framer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetic_track_steering_framer_core
// Track steering tick in, 16-byte drive command frame out, byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_valid / o_stall): one request per control tick with
//    sensor bits, card event and code, and run enable. A request is taken
//    when i_valid is high and o_stall is low.
//  - Output channel (o_valid / i_stall): frame bytes in order, o_frame_last
//    marks the CRC high byte. A byte moves when o_valid is high and i_stall
//    is low; while i_stall is high the byte holds.
//  - Config port: i_cfg_we writes i_cfg_data into register i_cfg_idx
//    (0 station address, 1 speed bias). Write only while the block is idle.
//  - First byte path: queue entry, back request register, output byte register.
//  - Throughput: one frame byte per cycle while i_stall is low, set by the
//    byte-serial output stage. Frames follow each other without gaps when
//    the next request is queued. Ticks that make no frame push nothing.
//  - A queue of FIFO_DEPTH frame requests lets new ticks in while the output
//    side is stalled; o_stall rises only once the queue is full.
//  - Reset: speeds, manoeuvre and tick count cleared, station address 1,
//    speed bias 130, queue and output empty.
// ----------------------------------------------------------------------------
module magnetic_track_steering_framer_core
    import mtsf_pkg::*;
#(
    parameter int FIFO_DEPTH = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // config port
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_idx,
    input  logic [9:0]              i_cfg_data,
    // tick requests
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [SENSOR_COUNT-1:0] i_hall_bits,
    input  logic                    i_card_event,
    input  logic [3:0]              i_card_code,
    input  logic                    i_run_enable,
    // frame bytes
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [7:0]              o_frame_byte,
    output logic                    o_frame_last
);

    // configuration registers
    logic [7:0] r_station_address;
    logic [9:0] r_speed_bias;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_address <= 8'd1;
            r_speed_bias      <= 10'd130;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STATION_ADDR: r_station_address <= i_cfg_data[7:0];
                CFG_SPEED_BIAS:   r_speed_bias      <= i_cfg_data;
                default:          r_speed_bias      <= r_speed_bias;
            endcase
        end
    end

    // front -> queue -> back
    logic       push;
    t_frame_req push_req;
    logic       q_full;
    logic       q_valid;
    t_frame_req q_req;
    logic       pop;

    mtsf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hall_bits  (i_hall_bits),
        .i_card_event (i_card_event),
        .i_card_code  (i_card_code),
        .i_run_enable (i_run_enable),
        .i_speed_bias (r_speed_bias),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_push_req   (push_req)
    );

    mtsf_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_req (push_req),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_req      (q_req),
        .i_pop      (pop)
    );

    // user keeps station address stable in flight (idle writes); not enforced
    mtsf_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_station_address (r_station_address),
        .i_q_valid         (q_valid),
        .i_q_req           (q_req),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_frame_byte      (o_frame_byte),
        .o_frame_last      (o_frame_last)
    );

    a_last_has_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("output byte dropped under stall");

endmodule
